### hw/rtl/rpcsv_pkg.sv
// Package: packet format constants and payload/result struct types for the checksum validator.
package rpcsv_pkg;

	localparam int unsigned PktLen     = 17;
	localparam int unsigned SumLen     = 13;
	localparam int unsigned PayloadLen = 10;
	localparam int unsigned AddrPos0   = 10;
	localparam int unsigned CntW       = 5;
	localparam int unsigned SumW       = 12;
	localparam int unsigned CfgIdxW    = 2;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_ADDR0 = 2'd0,
		CFG_ADDR1 = 2'd1,
		CFG_ADDR2 = 2'd2,
		CFG_NONE  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_start;
	} in_item_t;

	typedef struct packed {
		logic        packet_valid;
		logic [15:0] throttle;
		logic [15:0] pitch;
		logic [15:0] roll;
		logic [15:0] yaw;
		logic [7:0]  motor_off;
		logic [7:0]  alt_hold;
	} out_item_t;

endpackage

### hw/rtl/radio_packet_checksum_validator_unit.sv
// Top level: 17-byte packet validator with address match and additive checksum.
// Result path: a last packet byte passes through the input register, then the result
//   register, where the result is presented.
// Throughput: one byte per clock; in_stall rises only while a finished result waits
//   in the result register and the next last-byte would overwrite it.
// Reset (arst_n low, async): byte count, sum, checksum and held values clear to zero,
//   address match flag sets, address registers clear; payload bytes are not reset.
module radio_packet_checksum_validator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// input byte channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  rpcsv_pkg::in_item_t          in_data,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output rpcsv_pkg::out_item_t         out_data,
	// configuration write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rpcsv_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [7:0]                   cfg_data
);
	import rpcsv_pkg::*;

	// address registers
	logic [7:0] addr_q [3];

	// input register stage
	logic      valid_s1;
	in_item_t  item_s1;

	// packet assembly state
	logic [CntW-1:0] byte_count_q;
	logic [SumW-1:0] sum_q;
	logic [31:0]     cksum_q;
	logic            addr_ok_q;
	logic [7:0]      payload_q [PayloadLen];

	// held command values
	logic [15:0] axes_q [4];
	logic [7:0]  flags_q [2];

	// result register
	logic      out_valid_q;
	out_item_t out_q;

	// per-byte decode
	logic [CntW-1:0] idx;
	logic            last_s1;
	logic            s1_go;
	logic            s1_fire;
	logic [31:0]     cksum_next;
	logic            pkt_ok;

	// Config is always accepted; writes to the unused index are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q[0] <= '0;
			addr_q[1] <= '0;
			addr_q[2] <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ADDR0: addr_q[0] <= cfg_data;
				CFG_ADDR1: addr_q[1] <= cfg_data;
				CFG_ADDR2: addr_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Byte position: a start marker forces position 0 and drops any partial packet.
	always_comb begin
		if (item_s1.packet_start || (byte_count_q >= CntW'(PktLen))) begin
			idx = '0;
		end else begin
			idx = byte_count_q;
		end
	end

	assign last_s1 = (idx == CntW'(PktLen - 1));

	// Only the last byte needs the result register; every other byte always moves on.
	assign s1_go    = !(last_s1 && out_valid_q && out_stall);
	assign s1_fire  = valid_s1 && s1_go;
	assign in_stall = valid_s1 && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// Checksum bytes arrive big-endian and shift in from the bottom.
	assign cksum_next = {cksum_q[23:0], item_s1.data_byte};

	// Sum of 13 bytes fits in 12 bits, so the upper checksum bits must be zero.
	assign pkt_ok = addr_ok_q && (cksum_next == {{(32-SumW){1'b0}}, sum_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			sum_q        <= '0;
			cksum_q      <= '0;
			addr_ok_q    <= 1'b1;
		end else if (s1_fire) begin
			byte_count_q <= last_s1 ? '0 : idx + CntW'(1);
			if (idx == '0) begin
				sum_q     <= SumW'(item_s1.data_byte);
				cksum_q   <= '0;
				addr_ok_q <= 1'b1;
			end else begin
				if (idx < CntW'(SumLen)) begin
					sum_q <= sum_q + SumW'(item_s1.data_byte);
				end else begin
					cksum_q <= cksum_next;
				end
				if ((idx == CntW'(AddrPos0)     && item_s1.data_byte != addr_q[0]) ||
				    (idx == CntW'(AddrPos0 + 1) && item_s1.data_byte != addr_q[1]) ||
				    (idx == CntW'(AddrPos0 + 2) && item_s1.data_byte != addr_q[2])) begin
					addr_ok_q <= 1'b0;
				end
			end
		end
	end

	// Payload bytes 0..9 are always written before byte 16 reads them.
	always_ff @(posedge clk) begin
		if (s1_fire && idx < CntW'(PayloadLen)) begin
			payload_q[idx[3:0]] <= item_s1.data_byte;
		end
	end

	// Held values refresh only on a good packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) axes_q[i] <= '0;
			flags_q[0] <= '0;
			flags_q[1] <= '0;
		end else if (s1_fire && last_s1 && pkt_ok) begin
			axes_q[0]  <= {payload_q[0], payload_q[1]};
			axes_q[1]  <= {payload_q[2], payload_q[3]};
			axes_q[2]  <= {payload_q[4], payload_q[5]};
			axes_q[3]  <= {payload_q[6], payload_q[7]};
			flags_q[0] <= payload_q[8];
			flags_q[1] <= payload_q[9];
		end
	end

	// Result register: loads on the last byte, drains when downstream takes the transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			out_q.packet_valid <= pkt_ok;
			if (pkt_ok) begin
				out_q.throttle  <= {payload_q[0], payload_q[1]};
				out_q.pitch     <= {payload_q[2], payload_q[3]};
				out_q.roll      <= {payload_q[4], payload_q[5]};
				out_q.yaw       <= {payload_q[6], payload_q[7]};
				out_q.motor_off <= payload_q[8];
				out_q.alt_hold  <= payload_q[9];
			end else begin
				out_q.throttle  <= axes_q[0];
				out_q.pitch     <= axes_q[1];
				out_q.roll      <= axes_q[2];
				out_q.yaw       <= axes_q[3];
				out_q.motor_off <= flags_q[0];
				out_q.alt_hold  <= flags_q[1];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// byte position never runs past the last packet byte
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CntW'(PktLen - 1))
		else $error("byte count out of range");

	// a new result only follows a last byte leaving the input register
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_fire && last_s1))
		else $error("result without last byte");

	// input backs up only when a held result blocks the last byte
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && last_s1 && out_valid_q && out_stall))
		else $error("unexpected input stall");

	// a good packet result's throttle matches the held throttle it just loaded
	a_held_match: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.packet_valid) |-> (out_q.throttle == axes_q[0]))
		else $error("held throttle mismatch");

endmodule
